FILE: src/pip_pkg.sv
// Shared types, sizes and codes for the point-in-polygon tester.
// Used by every module of the block but pip_ram; depends on nothing.
`timescale 1ns / 1ps

package pip_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int COORD_BITS   = 16;

   localparam int ADDR_W   = $clog2(MAX_VERTICES);
   localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_W   = COORD_BITS + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((1 + CNT_W + 7) / 8) * 8;
   localparam int VERT_W     = 2 * COORD_BITS;

   typedef logic [ADDR_W-1:0]            addr_type;
   typedef logic [CNT_W-1:0]             count_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic [MODE_W-1:0]            mode_type;
   typedef logic [STATUS_W-1:0]          status_type;

   typedef struct packed {
      coord_type y;
      coord_type x;
   } vertex_type;

   localparam mode_type MODE_ADD   = 2'd0;
   localparam mode_type MODE_QUERY = 2'd1;
   localparam mode_type MODE_CLEAR = 2'd2;

   localparam status_type STAT_DONE = 2'd0;
   localparam status_type STAT_DUP  = 2'd1;
   localparam status_type STAT_FULL = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     accept;    // request transaction taken this cycle
      logic     rd_issue;  // an edge-walk step enters the pipeline
      logic     rd_first;  // step carries vertex 0
      logic     rd_close;  // step closes the polygon, no memory read
      addr_type rd_addr;
      logic     finish;    // execute the item and load the response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      count_type count;
      logic      pipe_busy;
      logic      out_free;
   } stat_type;

endpackage

FILE: src/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; holds the vertex store of the point-in-polygon tester.
`timescale 1ns / 1ps

module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pip_ctrl.sv
// Controller of the point-in-polygon tester: accepts items and walks the edges.
// Depends on pip_pkg; drives the datapath through pip_pkg::cmd_type.
`timescale 1ns / 1ps

module pip_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  pip_pkg::mode_type req_mode,
   input  pip_pkg::stat_type stat,
   output pip_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;
   pip_pkg::count_type idx_ff, idx_in;
   logic               accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.accept   = accept;
      cmd.rd_addr  = idx_ff[pip_pkg::ADDR_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = '0;
               if (req_mode == pip_pkg::MODE_QUERY && stat.count != '0) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            if (idx_ff < stat.count) begin
               cmd.rd_first = (idx_ff == '0);
               idx_in       = pip_pkg::count_type'(idx_ff + 1'b1);
            end else begin
               // Extra step that feeds the closing edge back to vertex 0.
               cmd.rd_close = 1'b1;
               state_in     = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!stat.pipe_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

`ifndef SYNTHESIS
   a_read_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> idx_ff <= stat.count)
      else $error("edge walk index ran past the vertex count");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> !stat.pipe_busy)
      else $error("response stage entered with crossings still in flight");

   a_close_then_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_close |=> state_ff == S_WAIT)
      else $error("closing edge not followed by the drain wait");
`endif

endmodule

FILE: src/pip_dp.sv
// Datapath of the point-in-polygon tester: vertex store, crossing pipeline,
// vertex count and response register. Depends on pip_pkg and pip_ram.
`timescale 1ns / 1ps

module pip_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pip_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  pip_pkg::mode_type                 req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pip_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output pip_pkg::status_type               rsp_tuser,
   input  pip_pkg::cmd_type                  cmd,
   output pip_pkg::stat_type                 stat
);

   // Latched item.
   pip_pkg::mode_type  mode_ff;
   pip_pkg::coord_type px_ff, py_ff;

   // Store bookkeeping.
   pip_pkg::count_type count_ff, count_in;
   pip_pkg::coord_type last_x_ff, last_y_ff;

   // Memory.
   logic                 wr_en;
   pip_pkg::vertex_type  wr_vert, rd_vert;

   // Edge walk pipeline.
   logic                 v1_vld_ff, v1_first_ff, v1_close_ff;
   pip_pkg::coord_type   first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   pip_pkg::coord_type   cur_x, cur_y;
   logic                 a_vld_ff, a_cond_ff;
   pip_pkg::diff_type    a_d_ff, a_dxp_ff, a_dxe_ff, a_dyp_ff;
   logic                 b_vld_ff, b_cond_ff, b_dpos_ff;
   pip_pkg::prod_type    b_lhs_ff, b_rhs_ff;
   logic                 crossing;
   logic                 parity_ff;

   // Response.
   logic                 rsp_vld_ff;
   logic                 rsp_inside_ff, fin_inside;
   pip_pkg::status_type  rsp_status_ff, fin_status;
   pip_pkg::count_type   rsp_count_ff;
   logic                 dup, full;

   pip_ram #(
      .WIDTH(pip_pkg::VERT_W),
      .DEPTH(pip_pkg::MAX_VERTICES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[pip_pkg::ADDR_W-1:0]),
      .wr_data(wr_vert),
      .rd_en  (cmd.rd_issue && !cmd.rd_close),
      .rd_addr(cmd.rd_addr),
      .rd_data(rd_vert)
   );

   assign wr_vert.x = px_ff;
   assign wr_vert.y = py_ff;

   // Item execution at finish time.
   assign dup  = (count_ff != '0) && (last_x_ff == px_ff) && (last_y_ff == py_ff);
   assign full = (count_ff == pip_pkg::count_type'(pip_pkg::MAX_VERTICES));

   always_comb begin
      wr_en      = 1'b0;
      count_in   = count_ff;
      fin_inside = 1'b0;
      fin_status = pip_pkg::STAT_DONE;
      unique case (mode_ff)
         pip_pkg::MODE_ADD: begin
            priority if (dup) begin
               fin_status = pip_pkg::STAT_DUP;
            end else if (full) begin
               fin_status = pip_pkg::STAT_FULL;
            end else begin
               wr_en    = cmd.finish;
               count_in = pip_pkg::count_type'(count_ff + 1'b1);
            end
         end
         pip_pkg::MODE_QUERY: fin_inside = parity_ff;
         pip_pkg::MODE_CLEAR: count_in   = '0;
         default: ;
      endcase
   end

   // Vertex fed to the edge stage: memory data, or vertex 0 on the closing step.
   assign cur_x = v1_close_ff ? first_x_ff : rd_vert.x;
   assign cur_y = v1_close_ff ? first_y_ff : rd_vert.y;

   // Edge (prev, cur) crosses when the query lies strictly left of it at py.
   assign crossing = b_vld_ff && b_cond_ff &&
                     (b_dpos_ff ? (b_lhs_ff < b_rhs_ff) : (b_lhs_ff > b_rhs_ff));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_tuser;
         px_ff   <= pip_pkg::coord_type'(req_tdata[pip_pkg::COORD_BITS-1:0]);
         py_ff   <= pip_pkg::coord_type'(req_tdata[2*pip_pkg::COORD_BITS-1:
                                                   pip_pkg::COORD_BITS]);
      end
      if (wr_en) begin
         last_x_ff <= px_ff;
         last_y_ff <= py_ff;
      end
      v1_first_ff <= cmd.rd_first;
      v1_close_ff <= cmd.rd_close;
      if (v1_vld_ff) begin
         if (v1_first_ff) begin
            first_x_ff <= cur_x;
            first_y_ff <= cur_y;
         end
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end
      a_cond_ff <= (prev_y_ff > py_ff) != (cur_y > py_ff);
      a_d_ff    <= pip_pkg::diff_type'(cur_y) - pip_pkg::diff_type'(prev_y_ff);
      a_dxp_ff  <= pip_pkg::diff_type'(px_ff) - pip_pkg::diff_type'(prev_x_ff);
      a_dxe_ff  <= pip_pkg::diff_type'(cur_x) - pip_pkg::diff_type'(prev_x_ff);
      a_dyp_ff  <= pip_pkg::diff_type'(py_ff) - pip_pkg::diff_type'(prev_y_ff);
      b_cond_ff <= a_cond_ff;
      b_dpos_ff <= (a_d_ff > 0);
      b_lhs_ff  <= pip_pkg::prod_type'(a_dxp_ff) * pip_pkg::prod_type'(a_d_ff);
      b_rhs_ff  <= pip_pkg::prod_type'(a_dxe_ff) * pip_pkg::prod_type'(a_dyp_ff);
      if (cmd.finish) begin
         rsp_inside_ff <= fin_inside;
         rsp_status_ff <= fin_status;
         rsp_count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         v1_vld_ff  <= 1'b0;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         parity_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            count_ff <= count_in;
         end
         v1_vld_ff <= cmd.rd_issue;
         a_vld_ff  <= v1_vld_ff && !v1_first_ff;
         b_vld_ff  <= a_vld_ff;
         if (cmd.accept) begin
            parity_ff <= 1'b0;
         end else if (crossing) begin
            parity_ff <= !parity_ff;
         end
         if (cmd.finish) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign stat.count     = count_ff;
   assign stat.pipe_busy = v1_vld_ff || a_vld_ff || b_vld_ff;
   assign stat.out_free  = !rsp_vld_ff || rsp_tready;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = pip_pkg::RSP_DATA_W'({rsp_count_ff, rsp_inside_ff});

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pip_pkg::count_type'(pip_pkg::MAX_VERTICES))
      else $error("vertex count above store depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_vld_ff || rsp_tready))
      else $error("response register loaded while a result is still pending");

   a_empty_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !(v1_vld_ff || a_vld_ff || b_vld_ff))
      else $error("new item accepted with the edge pipeline still busy");
`endif

endmodule

FILE: src/point_in_polygon_tester_top.sv
// Top level of the point-in-polygon tester: controller plus datapath.
// Depends on pip_pkg, pip_ctrl, pip_dp (which holds the pip_ram vertex store).
`timescale 1ns / 1ps

// The block holds up to 256 polygon vertices and answers even-odd inside
// tests for query points. Each request transaction produces exactly one
// response transaction. Add, clear and unused modes load the response
// register from the done state as soon as the response register is free;
// the block takes no new request before that load. A query on a non-empty
// store loads it after an edge walk that reads one vertex per cycle from
// the single read port of the vertex store; one extra step closes the
// polygon, and the crossing pipeline (vertex, differences, two multiplies,
// with the compare feeding the parity) drains before the result is posted.
// A query on an empty store skips the edge walk and answers like an add.
// The next request is taken while a finished response still waits for rsp_tready.

module point_in_polygon_tester_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pip_pkg::REQ_DATA_W-1:0] req_tdata,  // coord_x, coord_y
   input  logic [pip_pkg::MODE_W-1:0]     req_tuser,  // mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pip_pkg::RSP_DATA_W-1:0] rsp_tdata,  // inside_res, stored_count, zero pad
   output logic [pip_pkg::STATUS_W-1:0]   rsp_tuser   // status
);

   pip_pkg::cmd_type  cmd;
   pip_pkg::stat_type stat;

   pip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_mode  (req_tuser),
      .stat      (stat),
      .cmd       (cmd)
   );

   pip_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

FILE: tb/point_in_polygon_tester_top_tb.sv
// Self-checking testbench for point_in_polygon_tester_top.
// It drives point transactions and checks every response against a polygon predictor.
// Depends on pip_pkg and the RTL of the block.
`timescale 1ns / 1ps

module point_in_polygon_tester_top_tb;

   // The fourth mode code is not defined by the package, but the block must ignore it.
   localparam pip_pkg::mode_type MODE_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1240;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      logic                inside_res;
      pip_pkg::status_type status;
      pip_pkg::count_type  count;
   } answer_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [pip_pkg::REQ_DATA_W-1:0] req_tdata = '0;  // coord_x, coord_y
   logic [pip_pkg::MODE_W-1:0]     req_tuser = '0;  // mode
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [pip_pkg::RSP_DATA_W-1:0] rsp_tdata;       // inside_res, stored_count, zero pad
   logic [pip_pkg::STATUS_W-1:0]   rsp_tuser;       // status

   // Predictor state: the polygon as the block should hold it.
   pip_pkg::coord_type poly_x [pip_pkg::MAX_VERTICES];
   pip_pkg::coord_type poly_y [pip_pkg::MAX_VERTICES];
   pip_pkg::count_type poly_count = '0;

   answer_type pending_answers [$];
   answer_type head_answer;
   int         error_count = 0;
   int         items_sent = 0;
   int         req_burst = 0;
   int         rsp_burst = 0;
   bit         hold_request = 1'b0;

   point_in_polygon_tester_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Even-odd ray cast toward +x over every edge, the closing edge included.
   function automatic logic point_is_inside(pip_pkg::coord_type px, pip_pkg::coord_type py);
      logic    parity;
      int      j;
      longint  x1, y1, x2, y2, d, lhs, rhs;
      parity = 1'b0;
      for (int i = 0; i < int'(poly_count); i++) begin
         j = (i + 1 == int'(poly_count)) ? 0 : i + 1;
         x1 = longint'(poly_x[i]);
         y1 = longint'(poly_y[i]);
         x2 = longint'(poly_x[j]);
         y2 = longint'(poly_y[j]);
         if ((y1 > longint'(py)) != (y2 > longint'(py))) begin
            d = y2 - y1;
            lhs = (longint'(px) - x1) * d;
            rhs = (x2 - x1) * (longint'(py) - y1);
            if ((d > 0) ? (lhs < rhs) : (lhs > rhs))
               parity = ~parity;
         end
      end
      return parity;
   endfunction

   function automatic answer_type apply_item(pip_pkg::mode_type m, pip_pkg::coord_type px,
                                             pip_pkg::coord_type py);
      answer_type a;
      a.inside_res = 1'b0;
      a.status = pip_pkg::STAT_DONE;
      case (m)
         pip_pkg::MODE_ADD: begin
            if (poly_count > 0 && poly_x[poly_count-1] == px && poly_y[poly_count-1] == py) begin
               a.status = pip_pkg::STAT_DUP;
            end else if (poly_count >= pip_pkg::MAX_VERTICES) begin
               a.status = pip_pkg::STAT_FULL;
            end else begin
               poly_x[poly_count] = px;
               poly_y[poly_count] = py;
               poly_count = poly_count + 1'b1;
            end
         end
         pip_pkg::MODE_QUERY: begin
            a.inside_res = point_is_inside(px, py);
         end
         pip_pkg::MODE_CLEAR: begin
            poly_count = '0;
         end
         default: begin
         end
      endcase
      a.count = poly_count;
      return a;
   endfunction

   // Idle cycles before the next transaction, with occasional stretches of none.
   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      if ($urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(1, 18);
   endfunction

   function automatic pip_pkg::coord_type clamp_coord(int v);
      if (v > 32767)
         return pip_pkg::coord_type'(32767);
      if (v < -32768)
         return pip_pkg::coord_type'(-32768);
      return pip_pkg::coord_type'(v);
   endfunction

   function automatic pip_pkg::coord_type rand_coord();
      return pip_pkg::coord_type'($urandom());
   endfunction

   function automatic pip_pkg::coord_type near_coord(int center, int radius);
      return clamp_coord(center + int'($urandom_range(0, 2 * radius)) - radius);
   endfunction

   // Offers one transaction and records the predicted answer once it is taken.
   // The valid stays high across back-to-back transactions.
   task automatic send_item(pip_pkg::mode_type m, pip_pkg::coord_type px,
                            pip_pkg::coord_type py);
      int gap;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      req_tuser  <= m;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_answers.push_back(apply_item(m, px, py));
      items_sent++;
   endtask

   task automatic report_mismatch(string field, int expected_value, int actual_value);
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, field, expected_value, actual_value);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            error_count++;
            $display("%0t: response with no pending transaction, expected none, actual %h/%h",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            head_answer = pending_answers.pop_front();
            if (rsp_tdata[0] !== head_answer.inside_res)
               report_mismatch("inside_res", head_answer.inside_res, rsp_tdata[0]);
            if (rsp_tuser !== head_answer.status)
               report_mismatch("status", head_answer.status, rsp_tuser);
            if (rsp_tdata[pip_pkg::CNT_W:1] !== head_answer.count)
               report_mismatch("stored_count", head_answer.count,
                               rsp_tdata[pip_pkg::CNT_W:1]);
            if (rsp_tdata[pip_pkg::RSP_DATA_W-1:pip_pkg::CNT_W+1] !== '0)
               report_mismatch("pad", 0, rsp_tdata[pip_pkg::RSP_DATA_W-1:pip_pkg::CNT_W+1]);
         end
      end
   end

   // Response side: random stalls, plus one long hold-off when asked for.
   initial begin : response_sink
      int gap;
      wait (!reset);
      forever begin
         if (hold_request) begin
            gap = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            gap = draw_gap(rsp_burst);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic test_directed();
      send_item(pip_pkg::MODE_QUERY, 16'sd0, 16'sd0);
      send_item(MODE_UNUSED, 16'sd0, 16'sd0);
      send_item(pip_pkg::MODE_ADD, -16'sd32768, -16'sd32768);
      send_item(pip_pkg::MODE_QUERY, -16'sd32768, -16'sd32768);
      send_item(pip_pkg::MODE_ADD, -16'sd32768, -16'sd32768);
      send_item(pip_pkg::MODE_ADD, 16'sd32767, 16'sd32767);
      send_item(pip_pkg::MODE_QUERY, 16'sd0, 16'sd0);
      send_item(pip_pkg::MODE_ADD, 16'sd32767, -16'sd32768);
      send_item(pip_pkg::MODE_QUERY, 16'sd32766, 16'sd0);
      send_item(pip_pkg::MODE_QUERY, -16'sd32768, 16'sd32767);
      send_item(pip_pkg::MODE_QUERY, 16'sd32767, -16'sd32768);
      send_item(pip_pkg::MODE_CLEAR, 16'sd0, 16'sd0);
      send_item(pip_pkg::MODE_QUERY, 16'sd0, 16'sd0);
      // A square with horizontal edges; points on edges and corners probe the rule.
      send_item(pip_pkg::MODE_ADD, -16'sd100, -16'sd100);
      send_item(pip_pkg::MODE_ADD, 16'sd100, -16'sd100);
      send_item(pip_pkg::MODE_ADD, 16'sd100, 16'sd100);
      send_item(pip_pkg::MODE_ADD, -16'sd100, 16'sd100);
      send_item(pip_pkg::MODE_QUERY, 16'sd0, 16'sd0);
      send_item(pip_pkg::MODE_QUERY, 16'sd100, 16'sd0);
      send_item(pip_pkg::MODE_QUERY, -16'sd100, 16'sd0);
      send_item(pip_pkg::MODE_QUERY, 16'sd0, 16'sd100);
      send_item(pip_pkg::MODE_QUERY, 16'sd0, -16'sd100);
      send_item(pip_pkg::MODE_QUERY, -16'sd100, -16'sd100);
      send_item(pip_pkg::MODE_QUERY, 16'sd200, 16'sd0);
      send_item(MODE_UNUSED, -16'sd1, -16'sd1);
      send_item(pip_pkg::MODE_CLEAR, -16'sd1, 16'sd32767);
   endtask

   task automatic test_full_store();
      pip_pkg::coord_type last_x, last_y;
      send_item(pip_pkg::MODE_CLEAR, 16'sd0, 16'sd0);
      while (poly_count < pip_pkg::MAX_VERTICES)
         send_item(pip_pkg::MODE_ADD, rand_coord(), rand_coord());
      last_x = poly_x[pip_pkg::MAX_VERTICES-1];
      last_y = poly_y[pip_pkg::MAX_VERTICES-1];
      send_item(pip_pkg::MODE_ADD, last_x + 16'sd1, last_y);
      // At full capacity the duplicate check still wins over the full check.
      send_item(pip_pkg::MODE_ADD, last_x, last_y);
      repeat (6) send_item(pip_pkg::MODE_QUERY, rand_coord(), rand_coord());
      send_item(MODE_UNUSED, rand_coord(), rand_coord());
      send_item(pip_pkg::MODE_ADD, rand_coord(), rand_coord());
      send_item(pip_pkg::MODE_CLEAR, 16'sd0, 16'sd0);
   endtask

   task automatic test_backpressure();
      send_item(pip_pkg::MODE_ADD, -16'sd50, -16'sd40);
      send_item(pip_pkg::MODE_ADD, 16'sd60, -16'sd30);
      send_item(pip_pkg::MODE_ADD, 16'sd10, 16'sd70);
      hold_request = 1'b1;
      repeat (30) begin
         if ($urandom_range(0, 3) == 0)
            send_item(pip_pkg::MODE_ADD, near_coord(0, 80), near_coord(0, 80));
         else
            send_item(pip_pkg::MODE_QUERY, near_coord(0, 80), near_coord(0, 80));
      end
   endtask

   task automatic test_random_polygons();
      int n, k, cx, cy, radius, pick, j;
      while (items_sent < ITEM_TARGET) begin
         if (poly_count > 40 || $urandom_range(0, 3) != 0)
            send_item(pip_pkg::MODE_CLEAR, rand_coord(), rand_coord());
         pick = $urandom_range(0, 9);
         radius = (pick < 3) ? 8 : (pick < 8) ? 300 : 32767;
         cx = int'($urandom_range(0, 65535)) - 32768;
         cy = int'($urandom_range(0, 65535)) - 32768;
         pick = $urandom_range(0, 19);
         n = (pick == 0) ? $urandom_range(0, 2) :
             (pick < 3)  ? $urandom_range(13, 60) : $urandom_range(3, 12);
         repeat (n) begin
            if ($urandom_range(0, 11) == 0 && poly_count > 0)
               send_item(pip_pkg::MODE_ADD, poly_x[poly_count-1], poly_y[poly_count-1]);
            send_item(pip_pkg::MODE_ADD, near_coord(cx, radius), near_coord(cy, radius));
         end
         k = $urandom_range(3, 12);
         repeat (k) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               send_item(MODE_UNUSED, rand_coord(), rand_coord());
            end else if (pick == 1) begin
               send_item(pip_pkg::MODE_QUERY, rand_coord(), rand_coord());
            end else if (pick < 5 && poly_count > 0) begin
               // Rays through a vertex height exercise the half-open crossing rule.
               j = $urandom_range(0, poly_count - 1);
               send_item(pip_pkg::MODE_QUERY, near_coord(cx, radius), poly_y[j]);
            end else if (pick == 5 && poly_count > 0) begin
               j = $urandom_range(0, poly_count - 1);
               send_item(pip_pkg::MODE_QUERY, poly_x[j], poly_y[j]);
            end else begin
               send_item(pip_pkg::MODE_QUERY, near_coord(cx, radius),
                         near_coord(cy, radius));
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_store();
      test_backpressure();
      test_random_polygons();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(50_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
